// ===== src/sik_pkg.sv =====
// Shared constants, types and the arctangent table for the SCARA inverse kinematics block.
// Used by sik_cordic, sik_law and scara_inverse_kinematics; depends on nothing else.
`default_nettype none

package sik_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int ANGLE_ITER_DEF  = 16;

	// Angles: degrees with 16 fraction bits, signed
	localparam int ANGLE_W         = 28;
	localparam int CORDIC_PRESCALE = 24;
	localparam int COS_FRAC        = 30;
	localparam int LAW_XW          = 58;

	localparam int LEN_W  = 24;
	localparam int SPU_W  = 16;
	localparam int STEP_W = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_ARM    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHOULDER_SPU = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ELBOW_SPU    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_SPU     = 3'd4;

	localparam logic [LEN_W-1:0] ARM_LEN_RST = 24'd38400;
	localparam logic [SPU_W-1:0] SPU_RST     = 16'd256;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle;
		logic                      clamped;
	} law_res_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic signed [ANGLE_W-1:0] atan_q16(input int i);
		logic signed [ANGLE_W-1:0] v;
		case (i)
			0: v = ANGLE_W'(2949120);
			1: v = ANGLE_W'(1740967);
			2: v = ANGLE_W'(919879);
			3: v = ANGLE_W'(466945);
			4: v = ANGLE_W'(234379);
			5: v = ANGLE_W'(117304);
			6: v = ANGLE_W'(58666);
			7: v = ANGLE_W'(29335);
			8: v = ANGLE_W'(14668);
			9: v = ANGLE_W'(7334);
			10: v = ANGLE_W'(3667);
			11: v = ANGLE_W'(1833);
			12: v = ANGLE_W'(917);
			13: v = ANGLE_W'(458);
			14: v = ANGLE_W'(229);
			15: v = ANGLE_W'(115);
			16: v = ANGLE_W'(57);
			17: v = ANGLE_W'(29);
			18: v = ANGLE_W'(14);
			19: v = ANGLE_W'(7);
			20: v = ANGLE_W'(4);
			21: v = ANGLE_W'(2);
			22: v = ANGLE_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== src/sik_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, rounded down.
// Stand-alone; carries a sideband word alongside the operand.
`default_nettype none

module sik_isqrt #(
	parameter int N  = 48,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [N-1:0]    in_val,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [N/2-1:0]  out_root,
	output logic [SW-1:0]   out_side
);

	localparam int STAGES = N / 2;

	logic [N-1:0]  rem_s  [1:STAGES];
	logic [N-1:0]  res_s  [1:STAGES];
	logic [SW-1:0] side_s [1:STAGES];
	logic          vld_s  [1:STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic [N:0] BIT = (N + 1)'(1) << (N - 2 - 2 * k);
		logic [N-1:0]  rem_i;
		logic [N-1:0]  res_i;
		logic [SW-1:0] side_i;
		logic          vld_i;
		logic [N:0]    trial;

		if (k == 0) begin : g_first
			assign rem_i  = in_val;
			assign res_i  = '0;
			assign side_i = in_side;
			assign vld_i  = in_valid;
		end else begin : g_next
			assign rem_i  = rem_s[k];
			assign res_i  = res_s[k];
			assign side_i = side_s[k];
			assign vld_i  = vld_s[k];
		end

		assign trial = {1'b0, res_i} + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_i;
				if ({1'b0, rem_i} >= trial) begin
					rem_s[k+1] <= rem_i - trial[N-1:0];
					res_s[k+1] <= (res_i >> 1) + BIT[N-1:0];
				end else begin
					rem_s[k+1] <= rem_i;
					res_s[k+1] <= res_i >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign out_root  = res_s[STAGES][N/2-1:0];
	assign out_side  = side_s[STAGES];

endmodule

`default_nettype wire

// ===== src/sik_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in degrees with 16 fraction bits.
// Depends on sik_pkg for the angle width and the arctangent table.
`default_nettype none

module sik_cordic
	import sik_pkg::*;
#(
	parameter int XW   = 58,
	parameter int ITER = ANGLE_ITER_DEF,
	parameter int SW   = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [XW-1:0]      in_x,
	input  logic signed [XW-1:0]      in_y,
	input  logic [SW-1:0]             in_side,
	output logic                      out_valid,
	output logic signed [ANGLE_W-1:0] out_angle,
	output logic [SW-1:0]             out_side
);

	localparam logic signed [ANGLE_W-1:0] QUARTER = ANGLE_W'(90 << 16);

	logic signed [XW-1:0]      x_s    [0:ITER];
	logic signed [XW-1:0]      y_s    [0:ITER];
	logic signed [ANGLE_W-1:0] ang_s  [0:ITER];
	logic                      zero_s [0:ITER];
	logic [SW-1:0]             side_s [0:ITER];
	logic                      vld_s  [0:ITER];

	logic signed [XW-1:0]      pre_x;
	logic signed [XW-1:0]      pre_y;
	logic signed [ANGLE_W-1:0] pre_ang;

	// Fold the left half plane onto the right one
	always_comb begin
		pre_x   = in_x;
		pre_y   = in_y;
		pre_ang = '0;
		if (in_x < 0) begin
			if (in_y >= 0) begin
				pre_x   = in_y;
				pre_y   = -in_x;
				pre_ang = QUARTER;
			end else begin
				pre_x   = -in_y;
				pre_y   = in_x;
				pre_ang = -QUARTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= pre_x;
			y_s[0]    <= pre_y;
			ang_s[0]  <= pre_ang;
			zero_s[0] <= (in_x == '0) && (in_y == '0);
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_rot
		localparam logic signed [ANGLE_W-1:0] STEP_ANG = atan_q16(i);
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				side_s[i+1] <= side_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1]   <= x_s[i] + ys;
					y_s[i+1]   <= y_s[i] - xs;
					ang_s[i+1] <= ang_s[i] + STEP_ANG;
				end else begin
					x_s[i+1]   <= x_s[i] - ys;
					y_s[i+1]   <= y_s[i] + xs;
					ang_s[i+1] <= ang_s[i] - STEP_ANG;
				end
			end
		end
	end

	assign out_valid = vld_s[ITER];
	assign out_angle = zero_s[ITER] ? '0 : ang_s[ITER];
	assign out_side  = side_s[ITER];

endmodule

`default_nettype wire

// ===== src/sik_law.sv =====
// Law-of-cosines angle opposite side c: products, restoring divide, sine by square root, CORDIC.
// Depends on sik_pkg, sik_isqrt and sik_cordic.
`default_nettype none

module sik_law
	import sik_pkg::*;
#(
	parameter int AW   = 24,
	parameter int BW   = 24,
	parameter int CW   = 24,
	parameter int SW   = 1,
	parameter int ITER = ANGLE_ITER_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	input  logic [CW-1:0] c,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output law_res_t      out_res,
	output logic [SW-1:0] out_side
);

	localparam int ABW   = (AW > BW) ? AW : BW;
	localparam int MAXW  = (ABW > CW) ? ABW : CW;
	localparam int MW    = 2 * MAXW + 1;
	localparam int DW    = AW + BW + 1;
	localparam int DIVN  = COS_FRAC;
	localparam int MAGW  = COS_FRAC + 1;
	localparam int RW    = COS_FRAC + 2;
	localparam int SQW   = 2 * MAGW;
	localparam int ROOTW = SQW / 2;
	localparam int ISW   = RW + 2 + SW;
	localparam int CSW   = 2 + SW;
	localparam logic [MAGW-1:0] MAG_ONE = MAGW'(1) << COS_FRAC;
	localparam logic [SQW-1:0]  ONE_SQ  = SQW'(1) << (2 * COS_FRAC);

	// flag bits through the divider
	localparam int F_NEG  = 3;
	localparam int F_ZERO = 2;
	localparam int F_OVER = 1;
	localparam int F_EQ   = 0;

	logic [2*AW-1:0]    aa_s1;
	logic [2*BW-1:0]    bb_s1;
	logic [2*CW-1:0]    cc_s1;
	logic [AW+BW-1:0]   ab_s1;
	logic [SW-1:0]      side_s1;
	logic               vld_s1;

	logic [MW-1:0]      p_s2;
	logic [MW-1:0]      q_s2;
	logic [DW-1:0]      den_s2;
	logic [SW-1:0]      side_s2;
	logic               vld_s2;

	logic [MW-1:0]      m_s3;
	logic               neg_s3;
	logic [DW-1:0]      den_s3;
	logic [SW-1:0]      side_s3;
	logic               vld_s3;

	logic [DW-1:0]      rem_s4;
	logic [DW-1:0]      den_s4;
	logic [3:0]         flg_s4;
	logic [SW-1:0]      side_s4;
	logic               vld_s4;

	logic [DW-1:0]      rem_d  [1:DIVN];
	logic [DIVN-1:0]    quo_d  [1:DIVN];
	logic [DW-1:0]      den_d  [1:DIVN];
	logic [3:0]         flg_d  [1:DIVN];
	logic [SW-1:0]      side_d [1:DIVN];
	logic               vld_d  [1:DIVN];

	logic [MAGW-1:0]    mag_s5;
	logic               neg_s5;
	logic               zero_s5;
	logic               clamp_s5;
	logic [SW-1:0]      side_s5;
	logic               vld_s5;

	logic [SQW-1:0]     sq_s6;
	logic signed [RW-1:0] r_s6;
	logic               zero_s6;
	logic               clamp_s6;
	logic [SW-1:0]      side_s6;
	logic               vld_s6;

	logic [SQW-1:0]     t_s7;
	logic signed [RW-1:0] r_s7;
	logic               zero_s7;
	logic               clamp_s7;
	logic [SW-1:0]      side_s7;
	logic               vld_s7;

	logic               rt_valid;
	logic [ROOTW-1:0]   rt_root;
	logic [ISW-1:0]     rt_side;
	logic signed [RW-1:0] rt_r;
	logic               rt_zero;
	logic               rt_clamp;
	logic [SW-1:0]      rt_pass;
	logic signed [LAW_XW-1:0] cx;
	logic signed [LAW_XW-1:0] cy;

	logic               cor_valid;
	logic signed [ANGLE_W-1:0] cor_angle;
	logic [CSW-1:0]     cor_side;

	logic signed [ANGLE_W-1:0] angle_s8;
	logic               clamp_s8;
	logic [SW-1:0]      side_s8;
	logic               vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_d[DIVN];
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= cor_valid;
		end
	end

	// Squares and the cross product
	always_ff @(posedge clk) begin
		if (en) begin
			aa_s1   <= (2 * AW)'(a) * (2 * AW)'(a);
			bb_s1   <= (2 * BW)'(b) * (2 * BW)'(b);
			cc_s1   <= (2 * CW)'(c) * (2 * CW)'(c);
			ab_s1   <= (AW + BW)'(a) * (AW + BW)'(b);
			side_s1 <= in_side;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2    <= MW'(aa_s1) + MW'(bb_s1);
			q_s2    <= MW'(cc_s1);
			den_s2  <= {ab_s1, 1'b0};
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3  <= q_s2 > p_s2;
			m_s3    <= (q_s2 > p_s2) ? (q_s2 - p_s2) : (p_s2 - q_s2);
			den_s3  <= den_s2;
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4          <= m_s3[DW-1:0];
			den_s4          <= den_s3;
			flg_s4[F_NEG]   <= neg_s3;
			flg_s4[F_ZERO]  <= den_s3 == '0;
			flg_s4[F_OVER]  <= m_s3 > MW'(den_s3);
			flg_s4[F_EQ]    <= m_s3 == MW'(den_s3);
			side_s4         <= side_s3;
		end
	end

	// Restoring divide |num| / den, one quotient bit per stage
	for (genvar k = 0; k < DIVN; k++) begin : g_div
		logic [DW-1:0]   rem_i;
		logic [DIVN-1:0] quo_i;
		logic [DW-1:0]   den_i;
		logic [3:0]      flg_i;
		logic [SW-1:0]   side_i;
		logic            vld_i;
		logic [DW:0]     rem2;

		if (k == 0) begin : g_first
			assign rem_i  = rem_s4;
			assign quo_i  = '0;
			assign den_i  = den_s4;
			assign flg_i  = flg_s4;
			assign side_i = side_s4;
			assign vld_i  = vld_s4;
		end else begin : g_next
			assign rem_i  = rem_d[k];
			assign quo_i  = quo_d[k];
			assign den_i  = den_d[k];
			assign flg_i  = flg_d[k];
			assign side_i = side_d[k];
			assign vld_i  = vld_d[k];
		end

		assign rem2 = {rem_i, 1'b0};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[k+1] <= 1'b0;
			end else if (en) begin
				vld_d[k+1] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_d[k+1]  <= den_i;
				flg_d[k+1]  <= flg_i;
				side_d[k+1] <= side_i;
				if (rem2 >= {1'b0, den_i}) begin
					rem_d[k+1] <= DW'(rem2 - {1'b0, den_i});
					quo_d[k+1] <= {quo_i[DIVN-2:0], 1'b1};
				end else begin
					rem_d[k+1] <= rem2[DW-1:0];
					quo_d[k+1] <= {quo_i[DIVN-2:0], 1'b0};
				end
			end
		end
	end

	// Pick the cosine magnitude; a zero denominator gives angle 0 without a flag
	always_ff @(posedge clk) begin
		if (en) begin
			if (flg_d[DIVN][F_ZERO]) begin
				mag_s5 <= '0;
			end else if (flg_d[DIVN][F_OVER] || flg_d[DIVN][F_EQ]) begin
				mag_s5 <= MAG_ONE;
			end else begin
				mag_s5 <= {1'b0, quo_d[DIVN]};
			end
			clamp_s5 <= flg_d[DIVN][F_OVER] & ~flg_d[DIVN][F_ZERO];
			neg_s5   <= flg_d[DIVN][F_NEG];
			zero_s5  <= flg_d[DIVN][F_ZERO];
			side_s5  <= side_d[DIVN];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s6    <= SQW'(mag_s5) * SQW'(mag_s5);
			r_s6     <= neg_s5 ? -$signed({1'b0, mag_s5}) : $signed({1'b0, mag_s5});
			zero_s6  <= zero_s5;
			clamp_s6 <= clamp_s5;
			side_s6  <= side_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s7     <= ONE_SQ - sq_s6;
			r_s7     <= r_s6;
			zero_s7  <= zero_s6;
			clamp_s7 <= clamp_s6;
			side_s7  <= side_s6;
		end
	end

	sik_isqrt #(
		.N  (SQW),
		.SW (ISW)
	) u_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.in_val    (t_s7),
		.in_side   ({r_s7, zero_s7, clamp_s7, side_s7}),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_side  (rt_side)
	);

	assign {rt_r, rt_zero, rt_clamp, rt_pass} = rt_side;

	assign cx = $signed({{(LAW_XW - RW - CORDIC_PRESCALE){rt_r[RW-1]}}, rt_r,
		{CORDIC_PRESCALE{1'b0}}});
	assign cy = $signed({{(LAW_XW - ROOTW - CORDIC_PRESCALE){1'b0}}, rt_root,
		{CORDIC_PRESCALE{1'b0}}});

	sik_cordic #(
		.XW   (LAW_XW),
		.ITER (ITER),
		.SW   (CSW)
	) u_acos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rt_valid),
		.in_x      (cx),
		.in_y      (cy),
		.in_side   ({rt_zero, rt_clamp, rt_pass}),
		.out_valid (cor_valid),
		.out_angle (cor_angle),
		.out_side  (cor_side)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s8 <= cor_side[SW+1] ? '0 : cor_angle;
			clamp_s8 <= cor_side[SW];
			side_s8  <= cor_side[SW-1:0];
		end
	end

	assign out_valid       = vld_s8;
	assign out_res.angle   = angle_s8;
	assign out_res.clamped = clamp_s8;
	assign out_side        = side_s8;

endmodule

`default_nettype wire

// ===== src/scara_inverse_kinematics.sv =====
// Throughput: one point per cycle while the output is not stalled; the reach square root, the two law-of-cosines
// units and the CORDIC stages are fully pipelined with one step per stage.
// A stalled output beat freezes the whole pipeline; nothing is dropped.
// Reset empties the pipeline and loads the arm lengths and step factors to defaults.
// Depends on sik_pkg, sik_isqrt, sik_cordic and sik_law.
`default_nettype none

module scara_inverse_kinematics
	import sik_pkg::*;
#(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF,
	localparam int IN_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// target_x, target_y, target_z, zero fill
	input  logic [IN_W-1:0]       s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// shoulder_steps, elbow_steps, lift_steps
	output logic [3*STEP_W-1:0]   m_axis_tdata,
	// unreachable
	output logic [0:0]            m_axis_tuser,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int W     = COORD_WIDTH;
	localparam int XW    = W + CORDIC_PRESCALE + 3;
	localparam int RESW  = $bits(law_res_t);
	localparam int CSW   = 2 * RESW + W;
	localparam int SUMW  = ANGLE_W + 1;
	localparam int DEGW  = SUMW + 1 - 16;
	localparam int ZMW   = W - 8;
	localparam int APW   = DEGW + SPU_W;
	localparam int ZPW   = ZMW + SPU_W;

	logic [LEN_W-1:0] upper_q;
	logic [LEN_W-1:0] lower_q;
	logic [SPU_W-1:0] sh_spu_q;
	logic [SPU_W-1:0] el_spu_q;
	logic [SPU_W-1:0] lf_spu_q;

	logic en;

	logic signed [W-1:0] x_s1, y_s1, z_s1;
	logic                vld_s1;
	logic signed [W-1:0] x_s2, y_s2, z_s2;
	logic [W-1:0]        ax_s2, ay_s2;
	logic                vld_s2;
	logic signed [W-1:0] x_s3, y_s3, z_s3;
	logic [2*W-1:0]      sqx_s3, sqy_s3;
	logic                vld_s3;
	logic signed [W-1:0] x_s4, y_s4, z_s4;
	logic [2*W-1:0]      sum_s4;
	logic                vld_s4;

	logic                rc_valid;
	logic [W-1:0]        reach;
	logic [3*W-1:0]      rc_side;
	logic signed [W-1:0] rc_x, rc_y, rc_z;

	logic                el_valid;
	law_res_t            el_res;
	logic [2*W-1:0]      el_side;
	logic signed [W-1:0] el_x, el_y;
	logic                sh_valid;
	law_res_t            sh_res;
	logic [W-1:0]        sh_side;

	logic signed [XW-1:0] cx, cy;
	logic                cor_valid;
	logic signed [ANGLE_W-1:0] cor_angle;
	logic [CSW-1:0]      cor_side;
	law_res_t            co_el, co_sh;
	logic signed [W-1:0] co_z;

	logic signed [SUMW-1:0] sh_ang_s5, el_ang_s5;
	logic                zneg_s5, unr_s5;
	logic [ZMW-1:0]      zmag_s5;
	logic                vld_s5;

	logic                sh_neg_s6, el_neg_s6, zneg_s6, unr_s6;
	logic [SUMW-1:0]     sh_abs_s6, el_abs_s6;
	logic [ZMW-1:0]      zmag_s6;
	logic                vld_s6;

	logic                sh_neg_s7, el_neg_s7, zneg_s7, unr_s7;
	logic [DEGW-1:0]     sh_deg_s7, el_deg_s7;
	logic [ZMW-1:0]      zmag_s7;
	logic                vld_s7;

	logic                sh_neg_s8, el_neg_s8, zneg_s8, unr_s8;
	logic [APW-1:0]      sh_prod_s8, el_prod_s8;
	logic [ZPW-1:0]      z_prod_s8;
	logic                vld_s8;

	logic [STEP_W-1:0]   sh_steps_s9, el_steps_s9, lf_steps_s9;
	logic                unr_s9;
	logic                vld_s9;

	// Saturate a scaled magnitude to a signed 32-bit step count
	function automatic logic [STEP_W-1:0] sat_steps(input logic neg, input logic [63:0] m);
		logic [63:0] n;
		logic [STEP_W-1:0] v;
		n = -m;
		if (neg) begin
			v = (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : n[STEP_W-1:0];
		end else begin
			v = (m > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[STEP_W-1:0];
		end
		return v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= ARM_LEN_RST;
			lower_q  <= ARM_LEN_RST;
			sh_spu_q <= SPU_RST;
			el_spu_q <= SPU_RST;
			lf_spu_q <= SPU_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_UPPER_ARM:    upper_q  <= wr_data[LEN_W-1:0];
				REG_LOWER_ARM:    lower_q  <= wr_data[LEN_W-1:0];
				REG_SHOULDER_SPU: sh_spu_q <= wr_data[SPU_W-1:0];
				REG_ELBOW_SPU:    el_spu_q <= wr_data[SPU_W-1:0];
				REG_LIFT_SPU:     lf_spu_q <= wr_data[SPU_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold every stage while the output beat waits
	assign en            = ~vld_s9 | m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= cor_valid;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= s_axis_tdata[W-1:0];
			y_s1 <= s_axis_tdata[2*W-1:W];
			z_s1 <= s_axis_tdata[3*W-1:2*W];

			x_s2  <= x_s1;
			y_s2  <= y_s1;
			z_s2  <= z_s1;
			ax_s2 <= (x_s1 < 0) ? W'(-x_s1) : W'(x_s1);
			ay_s2 <= (y_s1 < 0) ? W'(-y_s1) : W'(y_s1);

			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			sqx_s3 <= (2 * W)'(ax_s2) * (2 * W)'(ax_s2);
			sqy_s3 <= (2 * W)'(ay_s2) * (2 * W)'(ay_s2);

			x_s4   <= x_s3;
			y_s4   <= y_s3;
			z_s4   <= z_s3;
			sum_s4 <= sqx_s3 + sqy_s3;
		end
	end

	sik_isqrt #(
		.N  (2 * W),
		.SW (3 * W)
	) u_reach (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s4),
		.in_val    (sum_s4),
		.in_side   ({z_s4, y_s4, x_s4}),
		.out_valid (rc_valid),
		.out_root  (reach),
		.out_side  (rc_side)
	);

	assign {rc_z, rc_y, rc_x} = rc_side;

	sik_law #(
		.AW   (LEN_W),
		.BW   (LEN_W),
		.CW   (W),
		.SW   (2 * W),
		.ITER (ANGLE_ITERATIONS)
	) u_elbow (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rc_valid),
		.a         (upper_q),
		.b         (lower_q),
		.c         (reach),
		.in_side   ({rc_y, rc_x}),
		.out_valid (el_valid),
		.out_res   (el_res),
		.out_side  (el_side)
	);

	sik_law #(
		.AW   (W),
		.BW   (LEN_W),
		.CW   (LEN_W),
		.SW   (W),
		.ITER (ANGLE_ITERATIONS)
	) u_shoulder (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rc_valid),
		.a         (reach),
		.b         (upper_q),
		.c         (lower_q),
		.in_side   (rc_z),
		.out_valid (sh_valid),
		.out_res   (sh_res),
		.out_side  (sh_side)
	);

	assign {el_y, el_x} = el_side;

	assign cx = $signed({{3{el_x[W-1]}}, el_x, {CORDIC_PRESCALE{1'b0}}});
	assign cy = $signed({{3{el_y[W-1]}}, el_y, {CORDIC_PRESCALE{1'b0}}});

	sik_cordic #(
		.XW   (XW),
		.ITER (ANGLE_ITERATIONS),
		.SW   (CSW)
	) u_bearing (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (el_valid & sh_valid),
		.in_x      (cx),
		.in_y      (cy),
		.in_side   ({el_res, sh_res, sh_side}),
		.out_valid (cor_valid),
		.out_angle (cor_angle),
		.out_side  (cor_side)
	);

	assign {co_el, co_sh, co_z} = cor_side;

	always_ff @(posedge clk) begin
		if (en) begin
			sh_ang_s5 <= SUMW'(cor_angle) + SUMW'(co_sh.angle);
			el_ang_s5 <= SUMW'(co_el.angle);
			zneg_s5   <= co_z < 0;
			zmag_s5   <= (co_z < 0) ? ZMW'(W'(-co_z) >> 8) : ZMW'(W'(co_z) >> 8);
			unr_s5    <= co_el.clamped | co_sh.clamped;

			sh_neg_s6 <= sh_ang_s5 < 0;
			el_neg_s6 <= el_ang_s5 < 0;
			sh_abs_s6 <= (sh_ang_s5 < 0) ? SUMW'(-sh_ang_s5) : SUMW'(sh_ang_s5);
			el_abs_s6 <= (el_ang_s5 < 0) ? SUMW'(-el_ang_s5) : SUMW'(el_ang_s5);
			zneg_s6   <= zneg_s5;
			zmag_s6   <= zmag_s5;
			unr_s6    <= unr_s5;

			// round to whole degrees, half away from zero
			sh_neg_s7 <= sh_neg_s6;
			el_neg_s7 <= el_neg_s6;
			sh_deg_s7 <= DEGW'(((SUMW + 1)'(sh_abs_s6) + (SUMW + 1)'(32768)) >> 16);
			el_deg_s7 <= DEGW'(((SUMW + 1)'(el_abs_s6) + (SUMW + 1)'(32768)) >> 16);
			zneg_s7   <= zneg_s6;
			zmag_s7   <= zmag_s6;
			unr_s7    <= unr_s6;

			sh_neg_s8  <= sh_neg_s7;
			el_neg_s8  <= el_neg_s7;
			zneg_s8    <= zneg_s7;
			sh_prod_s8 <= APW'(sh_deg_s7) * APW'(sh_spu_q);
			el_prod_s8 <= APW'(el_deg_s7) * APW'(el_spu_q);
			z_prod_s8  <= ZPW'(zmag_s7) * ZPW'(lf_spu_q);
			unr_s8     <= unr_s7;

			sh_steps_s9 <= sat_steps(sh_neg_s8, 64'(sh_prod_s8[APW-1:8]));
			el_steps_s9 <= sat_steps(el_neg_s8, 64'(el_prod_s8[APW-1:8]));
			lf_steps_s9 <= sat_steps(zneg_s8, 64'(z_prod_s8[ZPW-1:8]));
			unr_s9      <= unr_s8;
		end
	end

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tdata  = {lf_steps_s9, el_steps_s9, sh_steps_s9};
	assign m_axis_tuser  = unr_s9;

	assert property (@(posedge clk) disable iff (!arst_n) el_valid == sh_valid)
		else $error("elbow and shoulder law units out of step");

	assert property (@(posedge clk) disable iff (!arst_n) !s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no output beat waiting");

	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cor_valid) && $stable(vld_s5) && $stable(rc_valid))
		else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ===== tb/scara_ik_checker.sv =====
// Checker for the SCARA inverse kinematics block: watches the input, output and
// register write ports, predicts each result and compares it field by field.
// Depends only on the port layout of scara_inverse_kinematics.
`timescale 1ns / 1ps

module scara_ik_checker #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [95:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [23:0] wr_data,
	output int          fail_count,
	output int          pending
);

	localparam logic [2:0] IDX_UPPER    = 3'd0;
	localparam logic [2:0] IDX_LOWER    = 3'd1;
	localparam logic [2:0] IDX_SHOULDER = 3'd2;
	localparam logic [2:0] IDX_ELBOW    = 3'd3;
	localparam logic [2:0] IDX_LIFT     = 3'd4;
	localparam longint unsigned COS_ONE = 64'd1 << 30;

	localparam int ATAN_DEG [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0};

	typedef struct {
		logic [31:0] shoulder;
		logic [31:0] elbow;
		logic [31:0] lift;
		logic        unreach;
	} motor_steps_t;

	motor_steps_t steps_q[$];

	logic [23:0] upper_len, lower_len;
	logic [15:0] shoulder_spu, elbow_spu, lift_spu;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > n)
			probe >>= 2;
		while (probe != 0) begin
			if (n >= res + probe) begin
				n -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	// Vectoring rotation; arithmetic shifts floor toward minus infinity
	function automatic longint vec_atan2(longint y, longint x);
		longint ang, t, xs, ys;
		ang = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; ang = longint'(90) <<< 16;
			end else begin
				t = x; x = -y; y = t; ang = -(longint'(90) <<< 16);
			end
		end
		for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; ang += ATAN_DEG[i];
			end else begin
				x -= ys; y += xs; ang -= ATAN_DEG[i];
			end
		end
		return ang;
	endfunction

	// Angle opposite side c of triangle (a, b, c)
	function automatic longint opposite_angle(longint unsigned a, longint unsigned b,
			longint unsigned c, inout logic clamp);
		longint unsigned p, q, den, m, mag, rem, s;
		logic neg;
		longint r;
		p = a * a + b * b;
		q = c * c;
		den = 2 * a * b;
		neg = q > p;
		m = neg ? q - p : p - q;
		if (den == 0)
			return 0;
		if (m > den) begin
			clamp = 1'b1;
			mag = COS_ONE;
		end else if (m == den) begin
			mag = COS_ONE;
		end else begin
			mag = 0;
			rem = m;
			for (int i = 0; i < 30; i++) begin
				rem <<= 1;
				mag <<= 1;
				if (rem >= den) begin
					rem -= den;
					mag |= 1;
				end
			end
		end
		s = int_sqrt(COS_ONE * COS_ONE - mag * mag);
		r = neg ? -longint'(mag) : longint'(mag);
		return vec_atan2(longint'(s) <<< 24, r <<< 24);
	endfunction

	function automatic longint round_deg(longint a);
		longint unsigned m;
		m = a < 0 ? -a : a;
		m = (m + 32768) >> 16;
		return a < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] to_steps(longint units, logic [15:0] spu);
		longint unsigned m;
		m = ((units < 0) ? longint'(-units) : units) * longint'(spu);
		m >>= 8;
		if (units < 0)
			return (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(m));
		return (m > 64'h7fff_ffff) ? 32'h7fff_ffff : 32'(m);
	endfunction

	function automatic motor_steps_t solve_point(logic [71:0] d);
		motor_steps_t e;
		longint x, y, z, elbow, shoulder, zmm;
		longint unsigned ax, ay, az, c;
		logic clamp;
		x = longint'($signed(d[23:0]));
		y = longint'($signed(d[47:24]));
		z = longint'($signed(d[71:48]));
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		c = int_sqrt(ax * ax + ay * ay);
		clamp = 1'b0;
		elbow = opposite_angle(upper_len, lower_len, c, clamp);
		shoulder = vec_atan2(y <<< 24, x <<< 24)
			+ opposite_angle(c, upper_len, lower_len, clamp);
		az = (z < 0 ? -z : z) >> 8;
		zmm = z < 0 ? -longint'(az) : longint'(az);
		e.shoulder = to_steps(round_deg(shoulder), shoulder_spu);
		e.elbow = to_steps(round_deg(elbow), elbow_spu);
		e.lift = to_steps(zmm, lift_spu);
		e.unreach = clamp;
		return e;
	endfunction

	assign pending = steps_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_len <= 24'd38400;
			lower_len <= 24'd38400;
			shoulder_spu <= 16'd256;
			elbow_spu <= 16'd256;
			lift_spu <= 16'd256;
		end else if (wr_en) begin
			case (wr_index)
				IDX_UPPER:    upper_len <= wr_data;
				IDX_LOWER:    lower_len <= wr_data;
				IDX_SHOULDER: shoulder_spu <= wr_data[15:0];
				IDX_ELBOW:    elbow_spu <= wr_data[15:0];
				IDX_LIFT:     lift_spu <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	initial fail_count = 0;

	always @(posedge clk) begin
		motor_steps_t exp_s;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			steps_q.push_back(solve_point(s_axis_tdata));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (steps_q.size() == 0) begin
				$error("result beat with no point outstanding");
				fail_count++;
			end else begin
				exp_s = steps_q.pop_front();
				if (m_axis_tdata[31:0] !== exp_s.shoulder) begin
					$error("shoulder_steps: expected %0d, got %0d",
						$signed(exp_s.shoulder), $signed(m_axis_tdata[31:0]));
					fail_count++;
				end
				if (m_axis_tdata[63:32] !== exp_s.elbow) begin
					$error("elbow_steps: expected %0d, got %0d",
						$signed(exp_s.elbow), $signed(m_axis_tdata[63:32]));
					fail_count++;
				end
				if (m_axis_tdata[95:64] !== exp_s.lift) begin
					$error("lift_steps: expected %0d, got %0d",
						$signed(exp_s.lift), $signed(m_axis_tdata[95:64]));
					fail_count++;
				end
				if (m_axis_tuser[0] !== exp_s.unreach) begin
					$error("unreachable: expected %0b, got %0b",
						exp_s.unreach, m_axis_tuser[0]);
					fail_count++;
				end
			end
		end
	end

endmodule

// ===== tb/tb_scara_inverse_kinematics.sv =====
// Top of the SCARA inverse kinematics testbench: clock, reset, point and register
// stimulus, output back-pressure and the verdict.
// Depends on scara_inverse_kinematics, sik_pkg and scara_ik_checker.
`timescale 1ns / 1ps

module tb_scara_inverse_kinematics;
	import sik_pkg::*;

	localparam int DRAIN_CYCLES = 160;
	localparam int IDLE_LIMIT   = 20000;
	localparam int PHASES       = 8;
	localparam int PHASE_POINTS = 192;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [71:0]           s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [95:0]           m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	int fail_count, pending;
	int idle_cycles = 0;
	logic tx_gaps = 1'b1;
	logic rx_gaps = 1'b1;
	int stall_req = 0;
	int upper_cur = 38400, lower_cur = 38400;

	always #2 clk = ~clk;

	scara_inverse_kinematics u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	scara_ik_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_point(input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] z);
		int gap;
		gap = tx_gaps ? pick_gap() : 0;
		if (gap > 0 && s_axis_tvalid) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {z, y, x};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Let every outstanding result out, then hold off for the pipeline depth
	task automatic drain_pipe();
		s_axis_tvalid = 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		wr_index = idx;
		wr_data = val[23:0];
		wr_en = 1'b1;
		@(negedge clk);
		wr_en = 1'b0;
		if (idx == REG_UPPER_ARM)
			upper_cur = int'(val[23:0]);
		if (idx == REG_LOWER_ARM)
			lower_cur = int'(val[23:0]);
	endtask

	task automatic load_arm(input int unsigned up, input int unsigned lo, input int unsigned s0,
			input int unsigned s1, input int unsigned s2);
		write_reg(REG_UPPER_ARM, up);
		write_reg(REG_LOWER_ARM, lo);
		write_reg(REG_SHOULDER_SPU, s0);
		write_reg(REG_ELBOW_SPU, s1);
		write_reg(REG_LIFT_SPU, s2);
		// indexes past the list must be ignored
		write_reg(CFG_IDX_W'($urandom_range(5, 7)), $urandom);
	endtask

	task automatic random_point();
		int reach;
		logic [23:0] x, y;
		reach = upper_cur + lower_cur;
		reach = reach + reach / 8;
		if (reach > 8388607 || reach < 1)
			reach = 8388607;
		if ($urandom_range(0, 9) < 7) begin
			x = 24'($urandom_range(0, 2 * reach) - reach);
			y = 24'($urandom_range(0, 2 * reach) - reach);
		end else begin
			x = 24'($urandom);
			y = 24'($urandom);
		end
		send_point(x, y, 24'($urandom));
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int gap, seen;
		gap = 0;
		seen = 0;
		forever begin
			@(negedge clk);
			if (stall_req != seen) begin
				seen = stall_req;
				m_axis_tready = 1'b0;
				repeat (400) @(negedge clk);
			end
			if (!rx_gaps) begin
				m_axis_tready = 1'b1;
			end else if (gap > 0) begin
				m_axis_tready = 1'b0;
				gap--;
			end else begin
				m_axis_tready = 1'b1;
				gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed points at reset geometry (150 mm arms)
		send_point(24'd0, 24'd0, 24'd0);
		send_point(24'd76800, 24'd0, 24'd256);
		send_point(24'd0, 24'd76800, -24'sd256);
		send_point(24'd76801, 24'd0, 24'd1);
		send_point(-24'sd76800, 24'd0, -24'sd1);
		send_point(24'd0, -24'sd76800, 24'h7fffff);
		send_point(24'h7fffff, 24'h7fffff, 24'h800000);
		send_point(24'h800000, 24'h800000, 24'h7fffff);
		send_point(24'h800000, 24'd0, 24'd0);
		send_point(24'd0, 24'h800000, 24'd0);
		send_point(24'h7fffff, 24'h800000, 24'hffffff);
		send_point(-24'sd1, 24'd0, 24'd255);
		send_point(-24'sd1, -24'sd1, -24'sd255);
		send_point(24'd1, 24'd0, 24'd0);
		send_point(24'd38400, 24'd38400, 24'd25600);
		send_point(-24'sd38400, 24'd38400, 24'd0);
		send_point(-24'sd38400, -24'sd38400, 24'd0);
		send_point(24'd54306, 24'd0, 24'd0);
		send_point(24'd12, 24'd5, 24'd0);
		send_point(24'h555555, 24'haaaaaa, 24'h5a5a5a);
		send_point(24'haaaaaa, 24'h555555, 24'ha5a5a5);
		drain_pipe();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: load_arm(38400, 38400, 256, 256, 256);
				1: load_arm(0, 0, 65535, 65535, 65535);
				2: load_arm(16777215, 16777215, 0, 0, 0);
				3: load_arm(38400, 25600, 256, 512, 128);
				4: load_arm(1, 16777215, 1, 65535, 12345);
				7: load_arm($urandom_range(0, 16777215), $urandom_range(0, 16777215),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
				default: load_arm($urandom_range(1000, 200000), $urandom_range(1000, 200000),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			endcase
			tx_gaps = (p != 3 && p != 5);
			rx_gaps = (p != 5);
			for (int n = 0; n < PHASE_POINTS; n++) begin
				if (p == 3 && n == 8)
					stall_req++;
				random_point();
			end
			drain_pipe();
		end

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
